@@ hw/rtl/rit_pkg.sv @@
// Shared types, field widths and codes of the reference-counted inode table.
package rit_pkg;

	localparam int DEV_W     = 16;
	localparam int INO_W     = 32;
	localparam int SLOT_W    = 6;
	localparam int REF_W     = 8;
	localparam int SLOTS_DEF = 64;
	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 56;

	localparam logic [REF_W-1:0] REF_MAX = {REF_W{1'b1}};

	typedef enum logic {
		KIND_GET = 1'b0,
		KIND_PUT = 1'b1
	} kind_t;

	typedef enum logic [2:0] {
		ST_HIT       = 3'd0,
		ST_LOAD      = 3'd1,
		ST_FULL      = 3'd2,
		ST_HELD      = 3'd3,
		ST_CLEAN     = 3'd4,
		ST_WRITEBACK = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_GET_SCAN,
		S_GET_LAST,
		S_GET_WR,
		S_PUT_RD,
		S_PUT_WR,
		S_DONE
	} fsm_t;

	typedef struct packed {
		kind_t              kind;
		logic [DEV_W-1:0]   device;
		logic [INO_W-1:0]   inode_number;
		logic [SLOT_W-1:0]  slot;
		logic               modified;
	} item_t;

	typedef struct packed {
		status_t            status;
		logic [SLOT_W-1:0]  slot_index;
		logic [DEV_W-1:0]   out_device;
		logic [INO_W-1:0]   out_inode;
	} result_t;

	typedef struct packed {
		logic [DEV_W-1:0]   device;
		logic [INO_W-1:0]   inode;
		logic [REF_W-1:0]   refs;
		logic               dirty;
	} entry_t;

endpackage

@@ hw/rtl/rit_mem.sv @@
// Slot memory: one write port and one registered read port.
module rit_mem
	import rit_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF,
	parameter int AW    = $clog2(SLOTS)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  entry_t        wdata,
	input  logic [AW-1:0] raddr,
	output entry_t        rdata
);

	entry_t mem [SLOTS];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ hw/rtl/rit_seq.sv @@
// Sequencer with the shared slot compare unit: clear pass, get scan and put update.
module rit_seq
	import rit_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF,
	parameter int AW    = $clog2(SLOTS)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  item_t         in_item,
	output logic          res_valid,
	input  logic          res_ready,
	output result_t       res,
	output logic          mem_we,
	output logic [AW-1:0] mem_waddr,
	output entry_t        mem_wdata,
	output logic [AW-1:0] mem_raddr,
	input  entry_t        mem_rdata
);

	localparam logic [AW-1:0] LAST_ADDR = AW'(SLOTS - 1);
	localparam logic [31:0]   SLOTS_W32 = 32'(SLOTS);

	fsm_t            state_q, state_nxt;
	item_t           item_q;
	logic [AW-1:0]   addr_q;
	logic            rd_vld_s1;
	logic [AW-1:0]   rd_idx_s1;
	logic            match_found_q, free_found_q;
	logic [AW-1:0]   match_idx_q, free_idx_q;
	entry_t          match_ent_q;
	result_t         res_q, res_nxt;
	logic            res_load;
	logic            hit_now, free_now;
	logic            slot_oob;
	logic [AW+5:0]   slot_ext;
	logic [AW-1:0]   put_addr;
	logic            put_dirty;
	logic [REF_W-1:0] put_refs;

	function automatic logic [SLOT_W-1:0] low6(input logic [AW-1:0] a);
		logic [AW+5:0] w;
		w = {6'd0, a};
		return w[SLOT_W-1:0];
	endfunction

	assign hit_now  = rd_vld_s1 && mem_rdata.device == item_q.device &&
	                  mem_rdata.inode == item_q.inode_number;
	assign free_now = rd_vld_s1 && mem_rdata.refs == '0;
	assign slot_oob = {26'd0, item_q.slot} >= SLOTS_W32;
	assign slot_ext = {{AW{1'b0}}, item_q.slot};
	assign put_addr = slot_ext[AW-1:0];
	assign put_dirty = mem_rdata.dirty | item_q.modified;
	assign put_refs  = (mem_rdata.refs != '0) ? mem_rdata.refs - 1'b1 : mem_rdata.refs;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_CLEAR: begin
				if (addr_q == LAST_ADDR) state_nxt = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) state_nxt = (in_item.kind == KIND_GET) ? S_GET_SCAN : S_PUT_RD;
			end
			S_GET_SCAN: begin
				if (addr_q == LAST_ADDR) state_nxt = S_GET_LAST;
			end
			S_GET_LAST: state_nxt = S_GET_WR;
			S_GET_WR:   state_nxt = S_DONE;
			S_PUT_RD:   state_nxt = slot_oob ? S_DONE : S_PUT_WR;
			S_PUT_WR:   state_nxt = S_DONE;
			S_DONE: begin
				if (res_ready) state_nxt = S_IDLE;
			end
			default:    state_nxt = S_CLEAR;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		res_valid = 1'b0;
		res_load  = 1'b0;
		res_nxt   = '{status: ST_FULL, slot_index: '0, out_device: '0, out_inode: '0};
		mem_we    = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = '0;
		mem_raddr = addr_q;
		case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
			end
			S_IDLE: begin
				in_ready = 1'b1;
			end
			S_GET_WR: begin
				res_load = 1'b1;
				if (match_found_q) begin
					mem_we          = 1'b1;
					mem_waddr       = match_idx_q;
					mem_wdata       = match_ent_q;
					mem_wdata.refs  = (match_ent_q.refs != REF_MAX) ?
					                  match_ent_q.refs + 1'b1 : match_ent_q.refs;
					res_nxt = '{status: ST_HIT, slot_index: low6(match_idx_q),
					            out_device: match_ent_q.device, out_inode: match_ent_q.inode};
				end else if (free_found_q) begin
					mem_we    = 1'b1;
					mem_waddr = free_idx_q;
					mem_wdata = '{device: item_q.device, inode: item_q.inode_number,
					              refs: REF_W'(1), dirty: 1'b0};
					res_nxt = '{status: ST_LOAD, slot_index: low6(free_idx_q),
					            out_device: item_q.device, out_inode: item_q.inode_number};
				end
			end
			S_PUT_RD: begin
				mem_raddr = put_addr;
				if (slot_oob) begin
					res_load = 1'b1;
					res_nxt  = '{status: ST_CLEAN, slot_index: item_q.slot,
					             out_device: '0, out_inode: '0};
				end
			end
			S_PUT_WR: begin
				res_load  = 1'b1;
				mem_we    = 1'b1;
				mem_waddr = put_addr;
				mem_wdata = '{device: mem_rdata.device, inode: mem_rdata.inode,
				              refs: put_refs, dirty: put_dirty};
				res_nxt = '{status: ST_CLEAN, slot_index: item_q.slot,
				            out_device: mem_rdata.device, out_inode: mem_rdata.inode};
				if (put_refs != '0) begin
					res_nxt.status = ST_HELD;
				end else if (put_dirty) begin
					res_nxt.status  = ST_WRITEBACK;
					mem_wdata.dirty = 1'b0;
				end
			end
			S_DONE: begin
				res_valid = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			addr_q        <= '0;
			rd_vld_s1     <= 1'b0;
			match_found_q <= 1'b0;
			free_found_q  <= 1'b0;
		end else begin
			state_q   <= state_nxt;
			rd_vld_s1 <= (state_q == S_GET_SCAN);
			if (state_q == S_CLEAR || state_q == S_GET_SCAN) begin
				addr_q <= (addr_q == LAST_ADDR) ? '0 : addr_q + 1'b1;
			end else if (state_q == S_IDLE) begin
				addr_q <= '0;
			end
			if (state_q == S_IDLE) begin
				match_found_q <= 1'b0;
				free_found_q  <= 1'b0;
			end else begin
				if (hit_now && !match_found_q) match_found_q <= 1'b1;
				if (free_now && !free_found_q) free_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= addr_q;
		if (state_q == S_IDLE && in_valid) begin
			item_q <= in_item;
		end
		if (hit_now && !match_found_q) begin
			match_idx_q <= rd_idx_s1;
			match_ent_q <= mem_rdata;
		end
		if (free_now && !free_found_q) begin
			free_idx_q <= rd_idx_s1;
		end
		if (res_load) begin
			res_q <= res_nxt;
		end
	end

	assign res = res_q;

	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_GET_SCAN || state_q == S_GET_LAST) |-> !mem_we)
		else $error("slot memory written during a get scan");

	a_start_path: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && in_valid) |=> (state_q == S_GET_SCAN || state_q == S_PUT_RD))
		else $error("accepted beat did not start a get scan or a put read");

	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.status == ST_FULL) |->
		(res.slot_index == '0 && res.out_device == '0 && res.out_inode == '0))
		else $error("full result carries nonzero slot data");

	a_put_no_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PUT_WR) |-> (mem_wdata.refs <= mem_rdata.refs))
		else $error("put raised a reference count");

	a_get_refs_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_GET_WR && mem_we) |-> (mem_wdata.refs != '0))
		else $error("get left a zero reference count");

endmodule

@@ hw/rtl/refcounted_inode_table_top.sv @@
// Top level of the reference-counted inode table: stream ports and output register.
//
//  Channel  Dir  Beat fields (tdata low bit up | tuser)
//  s_*      in   device 16, inode_number 32, slot 6, modified 1 | kind 1
//  m_*      out  slot_index 6, out_device 16, out_inode 32 | status 3
//
// A get reads every slot once through the single memory read port and compares
// it in the shared compare unit. A put reads its own slot and writes it back,
// or skips the write when its slot lies beyond the table.
// After reset a clearing pass zeroes every slot of the slot memory; s_tready
// stays low during it. A finished result waits in the output register while the
// next beat is taken, and the sequencer holds until that register is free.
module refcounted_inode_table_top
	import rit_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // device, inode_number, slot, modified
	input  logic                  s_tuser,  // kind
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,  // slot_index, out_device, out_inode
	output logic [2:0]            m_tuser   // status
);

	localparam int AW = $clog2(SLOTS);

	item_t         in_item;
	result_t       res;
	logic          res_valid, res_ready;
	logic          mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	entry_t        mem_wdata, mem_rdata;
	logic          m_tvalid_q;
	result_t       out_q;

	assign in_item = '{kind: kind_t'(s_tuser), device: s_tdata[15:0],
	                   inode_number: s_tdata[47:16], slot: s_tdata[53:48],
	                   modified: s_tdata[54]};

	rit_seq #(.SLOTS(SLOTS), .AW(AW)) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_item   (in_item),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	rit_mem #(.SLOTS(SLOTS), .AW(AW)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = out_q.status;
	assign m_tdata  = {2'b00, out_q.out_inode, out_q.out_device, out_q.slot_index};

endmodule
